// ----- rtl/core/smd_pkg.sv -----
// shared types and constants of the sorted intensity mismatch distance block
`default_nettype none
package smd_pkg;
    localparam int PIX_W      = 16;
    localparam int CFG_W      = 11;
    localparam int DIST_W     = 24;
    localparam int CNT_MAX_W  = 17;
    localparam logic [CFG_W-1:0]  MIN_COUNT_RESET = 11'd5;
    localparam logic [DIST_W-1:0] DIST_MAX        = 24'hFFFFFF;

    typedef struct packed {
        logic [CNT_MAX_W-1:0] cnt0;
        logic [CNT_MAX_W-1:0] cnt1;
        logic                 dropped;
    } t_job;
endpackage
`default_nettype wire

// ----- rtl/core/smd_ifs.sv -----
// word channels of the block: pixels in, results out, configuration writes
`default_nettype none
interface smd_pix_if;
    logic        valid;
    logic        ready;
    logic        region;
    logic [15:0] intensity;
    logic        last;
    modport source(output valid, region, intensity, last, input ready);
    modport sink(input valid, region, intensity, last, output ready);
endinterface

interface smd_res_if;
    logic        valid;
    logic        ready;
    logic        valid_res;
    logic [23:0] distance;
    logic        overflow;
    modport source(output valid, valid_res, distance, overflow, input ready);
    modport sink(input valid, valid_res, distance, overflow, output ready);
endinterface

interface smd_cfg_if;
    logic        valid;
    logic        ready;
    logic [10:0] data;
    modport source(output valid, data, input ready);
    modport sink(input valid, data, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/sorted_intensity_mismatch_distance.sv -----
// top level: sorted intensity mismatch distance with two region stores
//
//  channel  dir  fields                                when taken
//  i_pix    in   region, intensity, last               valid && ready
//  o_res    out  valid_res, distance, overflow         valid && ready
//  i_cfg    in   data (min_count)                      valid && ready
//
// pixels load at one word per cycle; the last word closes the pair of regions
// after it, pixels stall until the job ends: insertion sort of both regions in
// the stores, the sum over the min(n0, n1) pairs and the division by that count
// in the restoring divider
// the result register lets loading of the next regions start while it waits
// synchronous active-low reset; stores hold no reset value
`default_nettype none
module sorted_intensity_mismatch_distance import smd_pkg::*; #(
    parameter int REGION_DEPTH  = 1024,
    parameter int FRACTION_BITS = 8
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    smd_pix_if.sink   i_pix,
    smd_res_if.source o_res,
    smd_cfg_if.sink   i_cfg
);
    localparam int AW = $clog2(REGION_DEPTH);
    localparam int CW = $clog2(REGION_DEPTH + 1);

    logic [CFG_W-1:0] r_min_count;
    logic             f_we0, f_we1, b_we0, b_we1, pop, done, job_valid;
    logic [AW-1:0]    f_waddr, b_waddr, b_raddr;
    logic [PIX_W-1:0] f_wdata, b_wdata, rdata0, rdata1;
    t_job             job;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_count <= MIN_COUNT_RESET;
        end else if (i_cfg.valid) begin
            r_min_count <= i_cfg.data;
        end
    end

    smd_front #(.REGION_DEPTH(REGION_DEPTH), .CW(CW), .AW(AW)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pix       (i_pix),
        .o_we0       (f_we0),
        .o_we1       (f_we1),
        .o_waddr     (f_waddr),
        .o_wdata     (f_wdata),
        .i_pop       (pop),
        .i_done      (done),
        .o_job_valid (job_valid),
        .o_job       (job)
    );

    smd_back #(.FRACTION_BITS(FRACTION_BITS), .CW(CW), .AW(AW)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_min_count (r_min_count),
        .i_job_valid (job_valid),
        .i_job       (job),
        .o_pop       (pop),
        .o_done      (done),
        .o_we0       (b_we0),
        .o_we1       (b_we1),
        .o_waddr     (b_waddr),
        .o_wdata     (b_wdata),
        .o_raddr     (b_raddr),
        .i_rdata0    (rdata0),
        .i_rdata1    (rdata1),
        .o_res       (o_res)
    );

    // front and back never write in the same cycle
    smd_ram #(.WIDTH(PIX_W), .DEPTH(REGION_DEPTH)) u_first_store (
        .i_clk   (i_clk),
        .i_we    (f_we0 || b_we0),
        .i_waddr (b_we0 ? b_waddr : f_waddr),
        .i_wdata (b_we0 ? b_wdata : f_wdata),
        .i_raddr (b_raddr),
        .o_rdata (rdata0)
    );

    smd_ram #(.WIDTH(PIX_W), .DEPTH(REGION_DEPTH)) u_second_store (
        .i_clk   (i_clk),
        .i_we    (f_we1 || b_we1),
        .i_waddr (b_we1 ? b_waddr : f_waddr),
        .i_wdata (b_we1 ? b_wdata : f_wdata),
        .i_raddr (b_raddr),
        .o_rdata (rdata1)
    );
endmodule
`default_nettype wire

// ----- rtl/core/smd_ram.sv -----
// generic single write, single registered read memory
`default_nettype none
module smd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ----- rtl/core/smd_div.sv -----
// restoring divider, one quotient bit per cycle
`default_nettype none
module smd_div #(
    parameter int DW = 43,
    parameter int VW = 11
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [DW-1:0] i_dividend,
    input  wire logic [VW-1:0] i_divisor,
    output logic               o_done,
    output logic      [DW-1:0] o_quotient
);
    localparam int KW = $clog2(DW + 1);

    logic [VW-1:0] r_rem, r_dvs;
    logic [DW-1:0] r_quo;
    logic [KW-1:0] r_cnt;
    logic          r_run;
    logic [VW:0]   rem_sh;
    logic          fits;

    assign rem_sh     = {r_rem, r_quo[DW-1]};
    assign fits       = rem_sh >= {1'b0, r_dvs};
    assign o_quotient = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_cnt  <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= KW'(DW);
            end else if (r_run) begin
                r_cnt <= r_cnt - KW'(1);
                if (r_cnt == KW'(1)) begin
                    r_run  <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_run) begin
            r_rem <= fits ? VW'(rem_sh - {1'b0, r_dvs}) : rem_sh[VW-1:0];
            r_quo <= {r_quo[DW-2:0], fits};
        end
    end
endmodule
`default_nettype wire

// ----- rtl/core/smd_front.sv -----
// front end: stores pixels, counts regions, queues a job on the last word
`default_nettype none
module smd_front import smd_pkg::*; #(
    parameter int REGION_DEPTH = 1024,
    parameter int CW = 11,
    parameter int AW = 10
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    smd_pix_if.sink            i_pix,
    output logic               o_we0,
    output logic               o_we1,
    output logic [AW-1:0]      o_waddr,
    output logic [PIX_W-1:0]   o_wdata,
    input  wire logic          i_pop,
    input  wire logic          i_done,
    output logic               o_job_valid,
    output t_job               o_job
);
    logic [CW-1:0] r_cnt0, r_cnt1, n_cnt0, n_cnt1;
    logic          r_drop, r_busy;
    t_job          r_q [2];
    logic [1:0]    r_qn;
    logic          r_head;
    logic          acc, push, pop;
    t_job          new_job;

    assign i_pix.ready = !r_busy;
    assign acc   = i_pix.valid && i_pix.ready;
    assign o_we0 = acc && !i_pix.region && (r_cnt0 < CW'(REGION_DEPTH));
    assign o_we1 = acc && i_pix.region && (r_cnt1 < CW'(REGION_DEPTH));
    assign o_waddr = i_pix.region ? r_cnt1[AW-1:0] : r_cnt0[AW-1:0];
    assign o_wdata = i_pix.intensity;
    assign n_cnt0  = r_cnt0 + CW'(o_we0);
    assign n_cnt1  = r_cnt1 + CW'(o_we1);
    assign push    = acc && i_pix.last;
    assign pop     = i_pop && (r_qn != 2'd0);

    always_comb begin
        new_job.cnt0    = CNT_MAX_W'(n_cnt0);
        new_job.cnt1    = CNT_MAX_W'(n_cnt1);
        new_job.dropped = r_drop || (acc && !o_we0 && !o_we1);
    end

    assign o_job_valid = r_qn != 2'd0;
    assign o_job       = r_q[r_head];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt0 <= '0;
            r_cnt1 <= '0;
            r_drop <= 1'b0;
            r_busy <= 1'b0;
            r_qn   <= '0;
            r_head <= 1'b0;
        end else begin
            if (push) begin
                r_cnt0 <= '0;
                r_cnt1 <= '0;
                r_drop <= 1'b0;
                r_busy <= 1'b1;
            end else if (acc) begin
                r_cnt0 <= n_cnt0;
                r_cnt1 <= n_cnt1;
                r_drop <= new_job.dropped;
            end
            if (i_done) begin
                r_busy <= 1'b0;
            end
            r_qn <= r_qn + 2'(push) - 2'(pop);
            if (pop) begin
                r_head <= !r_head;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_head ^ r_qn[0]] <= new_job;
        end
    end
endmodule
`default_nettype wire

// ----- rtl/core/smd_back.sv -----
// back end: for a valid pairing sorts both stores, sums paired differences and divides; holds the result
`default_nettype none
module smd_back import smd_pkg::*; #(
    parameter int FRACTION_BITS = 8,
    parameter int CW = 11,
    parameter int AW = 10
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [CFG_W-1:0] i_min_count,
    input  wire logic             i_job_valid,
    input  t_job                  i_job,
    output logic                  o_pop,
    output logic                  o_done,
    output logic                  o_we0,
    output logic                  o_we1,
    output logic [AW-1:0]         o_waddr,
    output logic [PIX_W-1:0]      o_wdata,
    output logic [AW-1:0]         o_raddr,
    input  wire logic [PIX_W-1:0] i_rdata0,
    input  wire logic [PIX_W-1:0] i_rdata1,
    smd_res_if.source             o_res
);
    localparam int SW = CW + PIX_W;
    localparam int DW = SW + FRACTION_BITS;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_NEXT = 4'd1;
    localparam logic [3:0] S_LDV  = 4'd2;
    localparam logic [3:0] S_RD   = 4'd3;
    localparam logic [3:0] S_CMP  = 4'd4;
    localparam logic [3:0] S_SRD  = 4'd5;
    localparam logic [3:0] S_SACC = 4'd6;
    localparam logic [3:0] S_DIV  = 4'd7;
    localparam logic [3:0] S_OUT  = 4'd8;

    logic [3:0]        r_state;
    logic              r_sel;
    logic [CW-1:0]     r_c0, r_c1, r_n, r_i, r_j, r_k;
    logic [PIX_W-1:0]  r_v;
    logic [SW-1:0]     r_sum;
    logic              r_vres, r_ovf;
    logic [DIST_W-1:0] r_dist;
    logic              r_ov, r_ores, r_oovf;
    logic [DIST_W-1:0] r_odist;

    logic [CW-1:0]     j_cnt, j_c0, j_c1, j_n, cur_cnt;
    logic              j_ok;
    logic [PIX_W-1:0]  cur_d, diff;
    logic              move, we, can_load, div_start, div_done;
    logic [DW-1:0]     quo;

    assign j_c0 = i_job.cnt0[CW-1:0];
    assign j_c1 = i_job.cnt1[CW-1:0];
    assign j_n  = (j_c0 < j_c1) ? j_c0 : j_c1;
    assign j_ok = (32'(j_c0) >= 32'(i_min_count)) && (32'(j_c1) >= 32'(i_min_count))
                  && (j_n != '0);
    assign j_cnt   = j_n;
    assign cur_cnt = r_sel ? r_c1 : r_c0;
    assign cur_d   = r_sel ? i_rdata1 : i_rdata0;
    // first store ascending, second descending
    assign move    = r_sel ? (cur_d < r_v) : (cur_d > r_v);
    assign diff    = (i_rdata0 > i_rdata1) ? i_rdata0 - i_rdata1 : i_rdata1 - i_rdata0;
    assign can_load  = !r_ov || o_res.ready;
    assign o_pop     = (r_state == S_IDLE) && i_job_valid;
    assign o_done    = (r_state == S_OUT) && can_load;
    assign div_start = (r_state == S_SRD) && (r_k == r_n);

    always_comb begin
        o_raddr = '0;
        o_waddr = '0;
        o_wdata = r_v;
        we      = 1'b0;
        case (r_state)
            S_NEXT: o_raddr = r_i[AW-1:0];
            S_RD: begin
                if (r_j == '0) begin
                    we = 1'b1;
                end else begin
                    o_raddr = AW'(r_j - CW'(1));
                end
            end
            S_CMP: begin
                we      = 1'b1;
                o_waddr = r_j[AW-1:0];
                o_wdata = move ? cur_d : r_v;
            end
            S_SRD: o_raddr = r_k[AW-1:0];
            default: ;
        endcase
    end
    assign o_we0 = we && !r_sel;
    assign o_we1 = we && r_sel;

    smd_div #(.DW(DW), .VW(CW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (DW'(r_sum) << FRACTION_BITS),
        .i_divisor  (r_n),
        .o_done     (div_done),
        .o_quotient (quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            if (o_res.valid && o_res.ready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: if (i_job_valid) r_state <= j_ok ? S_NEXT : S_OUT;
                S_NEXT: begin
                    if (r_i >= cur_cnt) begin
                        if (r_sel) r_state <= S_SRD;
                    end else begin
                        r_state <= S_LDV;
                    end
                end
                S_LDV:  r_state <= S_RD;
                S_RD:   r_state <= (r_j == '0) ? S_NEXT : S_CMP;
                S_CMP:  r_state <= move ? S_RD : S_NEXT;
                S_SRD:  r_state <= div_start ? S_DIV : S_SACC;
                S_SACC: r_state <= S_SRD;
                S_DIV:  if (div_done) r_state <= S_OUT;
                S_OUT: begin
                    if (can_load) begin
                        r_ov    <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_c0   <= j_c0;
                r_c1   <= j_c1;
                r_n    <= j_cnt;
                r_sel  <= 1'b0;
                r_i    <= CW'(1);
                r_k    <= '0;
                r_sum  <= '0;
                r_vres <= j_ok;
                r_ovf  <= i_job.dropped;
                r_dist <= '0;
            end
            S_NEXT: begin
                if (r_i >= cur_cnt && !r_sel) begin
                    r_sel <= 1'b1;
                    r_i   <= CW'(1);
                end
            end
            S_LDV: begin
                r_v <= cur_d;
                r_j <= r_i;
            end
            S_RD: if (r_j == '0) r_i <= r_i + CW'(1);
            S_CMP: begin
                if (move) r_j <= r_j - CW'(1);
                else      r_i <= r_i + CW'(1);
            end
            S_SACC: begin
                r_sum <= r_sum + SW'(diff);
                r_k   <= r_k + CW'(1);
            end
            S_DIV: begin
                if (div_done) begin
                    r_dist <= (64'(quo) > 64'(DIST_MAX)) ? DIST_MAX : DIST_W'(quo);
                end
            end
            S_OUT: begin
                if (can_load) begin
                    r_ores  <= r_vres;
                    r_odist <= r_dist;
                    r_oovf  <= r_ovf;
                end
            end
            default: ;
        endcase
    end

    assign o_res.valid     = r_ov;
    assign o_res.valid_res = r_ores;
    assign o_res.distance  = r_odist;
    assign o_res.overflow  = r_oovf;

    a_inval_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !r_ores) |-> (r_odist == '0))
        else $error("invalid result carries a distance");
    a_div_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && div_done) |=> (r_state == S_OUT))
        else $error("divider finish missed");
    a_insert_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |-> (r_j <= r_i && r_j != '0))
        else $error("insertion index out of range");
    a_sum_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SACC) |-> (r_k < r_n))
        else $error("pair index beyond pairing count");
endmodule
`default_nettype wire

// ----- test/tb_sorted_intensity_mismatch_distance.sv -----
// testbench of the sorted intensity mismatch distance block: directed table, a full store, then random regions
`default_nettype none
module tb_sorted_intensity_mismatch_distance;
    import smd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 1024;
    localparam int FRAC  = 8;

    typedef struct packed {
        logic        valid_res;
        logic [23:0] distance;
        logic        overflow;
    } t_dist;

    typedef struct {
        logic        is_cfg;
        logic [10:0] cfg;
        logic        region;
        logic [15:0] intensity;
        logic        last;
        logic        typed;
        t_dist       want;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    smd_pix_if pix ();
    smd_res_if res ();
    smd_cfg_if cfg ();

    sorted_intensity_mismatch_distance dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_pix  (pix.sink),
        .o_res  (res.source),
        .i_cfg  (cfg.sink)
    );

    // predictor state
    logic [15:0] near_px[$];
    logic [15:0] far_px[$];
    logic        dropped;
    logic [10:0] min_pixels;

    t_dist expected_dist[$];
    int    errors;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #400ms;
        $display("sorted_intensity_mismatch_distance verification failed");
        $finish;
    end

    function automatic t_dist mismatch_mean(input logic [15:0] a_in[$],
                                            input logic [15:0] b_in[$], input logic drop,
                                            input logic [10:0] min_n);
        t_dist r;
        logic [15:0] a[$];
        logic [15:0] b[$];
        longint unsigned acc;
        longint unsigned q;
        int n;
        a = a_in;
        b = b_in;
        r = '0;
        r.overflow = drop;
        n = (a.size() < b.size()) ? a.size() : b.size();
        if (a.size() >= min_n && b.size() >= min_n && n > 0) begin
            a.sort();
            b.rsort();
            acc = 0;
            for (int i = 0; i < n; i++)
                acc += (a[i] > b[i]) ? a[i] - b[i] : b[i] - a[i];
            q = (acc << FRAC) / n;
            r.valid_res = 1'b1;
            r.distance = (q > 64'hFFFFFF) ? 24'hFFFFFF : q[23:0];
        end
        return r;
    endfunction

    // returns 1 when a result is due
    function automatic bit load_pixel(input logic region, input logic [15:0] v,
                                      input logic last);
        if (region == 1'b0) begin
            if (near_px.size() < DEPTH) near_px.push_back(v);
            else dropped = 1'b1;
        end else begin
            if (far_px.size() < DEPTH) far_px.push_back(v);
            else dropped = 1'b1;
        end
        if (!last) return 0;
        expected_dist.push_back(mismatch_mean(near_px, far_px, dropped, min_pixels));
        near_px.delete();
        far_px.delete();
        dropped = 1'b0;
        return 1;
    endfunction

    // valid stays high after a word unless the next word waits
    task automatic send_pixel(input logic region, input logic [15:0] v, input logic last);
        int idle;
        idle = $urandom_range(0, 3);
        if (idle > 0) begin
            pix.valid <= 1'b0;
            repeat (idle) @(posedge i_clk);
        end
        pix.valid     <= 1'b1;
        pix.region    <= region;
        pix.intensity <= v;
        pix.last      <= last;
        @(posedge i_clk);
        while (!pix.ready) @(posedge i_clk);
        void'(load_pixel(region, v, last));
    endtask

    task automatic drain();
        pix.valid <= 1'b0;
        while (expected_dist.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    task automatic write_min(input logic [10:0] v);
        drain();
        cfg.valid <= 1'b1;
        cfg.data  <= v;
        @(posedge i_clk);
        while (!cfg.ready) @(posedge i_clk);
        cfg.valid <= 1'b0;
        min_pixels = v;
    endtask

    task automatic send_region_set(input int n0, input int n1, input bit narrow);
        int total;
        int k0;
        logic [15:0] v;
        total = n0 + n1;
        k0 = 0;
        for (int i = 0; i < total; i++) begin
            logic r;
            r = (k0 < n0 && ($urandom_range(0, 1) == 0 || i - k0 >= n1)) ? 1'b0 : 1'b1;
            if (r == 1'b0) k0++;
            v = narrow ? 16'($urandom_range(0, 15) + (r ? 16'hFFF0 : 16'h0))
                       : 16'($urandom);
            send_pixel(r, v, i == total - 1);
        end
    endtask

    // result side
    initial begin
        t_dist got;
        t_dist want;
        int    idle;
        res.ready = 1'b0;
        @(posedge i_clk);
        forever begin
            while (!(res.valid && i_rst_n)) @(posedge i_clk);
            idle = $urandom_range(0, 3);
            repeat (idle) @(posedge i_clk);
            res.ready <= 1'b1;
            @(posedge i_clk);
            if (res.valid && res.ready && i_rst_n) begin
                got = '{res.valid_res, res.distance, res.overflow};
                if (expected_dist.size() == 0) begin
                    $error("result with nothing expected: %p", got);
                    errors++;
                end else begin
                    want = expected_dist.pop_front();
                    if (got.valid_res !== want.valid_res) begin
                        $error("valid_res expected %0d actual %0d", want.valid_res,
                               got.valid_res);
                        errors++;
                    end
                    if (got.distance !== want.distance) begin
                        $error("distance expected %0h actual %0h", want.distance,
                               got.distance);
                        errors++;
                    end
                    if (got.overflow !== want.overflow) begin
                        $error("overflow expected %0d actual %0d", want.overflow,
                               got.overflow);
                        errors++;
                    end
                end
            end
            res.ready <= 1'b0;
            @(posedge i_clk);
        end
    end

    initial begin
        t_row rows[$];
        t_dist chk;
        int sets;
        errors = 0;
        dropped = 1'b0;
        min_pixels = MIN_COUNT_RESET;
        pix.valid = 1'b0;
        pix.region = 1'b0;
        pix.intensity = '0;
        pix.last = 1'b0;
        cfg.valid = 1'b0;
        cfg.data = '0;
        i_rst_n = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: lone last after reset gives invalid, then extremes with min_count 1
        rows.push_back('{0, 0, 0, 16'h0000, 1, 1, t_dist'{1'b0, 24'h0, 1'b0}});
        rows.push_back('{1, 11'd1, 0, 0, 0, 0, '0});
        rows.push_back('{0, 0, 0, 16'h0000, 0, 0, '0});
        rows.push_back('{0, 0, 1, 16'hFFFF, 1, 1, t_dist'{1'b1, 24'hFFFF00, 1'b0}});
        rows.push_back('{0, 0, 1, 16'h1234, 0, 0, '0});
        rows.push_back('{0, 0, 0, 16'h1234, 1, 1, t_dist'{1'b1, 24'h0, 1'b0}});
        rows.push_back('{0, 0, 0, 16'h0003, 0, 0, '0});
        rows.push_back('{0, 0, 0, 16'h0001, 0, 0, '0});
        rows.push_back('{0, 0, 1, 16'h0002, 0, 0, '0});
        rows.push_back('{0, 0, 1, 16'h0007, 1, 0, '0});
        // empty pairing with min_count 0
        rows.push_back('{1, 11'd0, 0, 0, 0, 0, '0});
        rows.push_back('{0, 0, 1, 16'hAAAA, 1, 1, t_dist'{1'b0, 24'h0, 1'b0}});
        // min_count beyond the pixels sent, then beyond the store depth
        rows.push_back('{1, 11'd1024, 0, 0, 0, 0, '0});
        rows.push_back('{0, 0, 0, 16'h5555, 0, 0, '0});
        rows.push_back('{0, 0, 1, 16'h5555, 1, 1, t_dist'{1'b0, 24'h0, 1'b0}});
        rows.push_back('{1, 11'h7FF, 0, 0, 0, 0, '0});
        rows.push_back('{0, 0, 1, 16'h8000, 1, 1, t_dist'{1'b0, 24'h0, 1'b0}});
        rows.push_back('{1, MIN_COUNT_RESET, 0, 0, 0, 0, '0});

        foreach (rows[i]) begin
            if (rows[i].is_cfg) write_min(rows[i].cfg);
            else begin
                send_pixel(rows[i].region, rows[i].intensity, rows[i].last);
                if (rows[i].typed) begin
                    chk = expected_dist[$];
                    expected_dist[$] = rows[i].want;
                    if (chk !== rows[i].want) begin
                        $error("predictor row %0d expected %p actual %p", i,
                               rows[i].want, chk);
                        errors++;
                    end
                end
            end
        end

        // store full: first region at capacity plus drops
        write_min(11'd1);
        send_region_set(DEPTH + 3, 2, 1'b0);
        drain();

        // random sets of up to eight pixels per region
        sets = 0;
        while (sets < 40) begin
            int n0, n1;
            if (sets % 15 == 7)
                write_min(11'($urandom_range(0, 8)));
            n0 = $urandom_range(0, 8);
            n1 = $urandom_range(0, 8);
            send_region_set(n0, n1, $urandom_range(0, 3) == 0);
            sets++;
            if (sets % 20 == 0) drain();
        end
        write_min(11'd1);
        send_region_set(1, 1, 1'b0);

        drain();
        if (errors == 0)
            $display("sorted_intensity_mismatch_distance verification clean");
        else
            $display("sorted_intensity_mismatch_distance verification failed");
        $finish;
    end
endmodule
`default_nettype wire

// ----- files.f -----
rtl/core/smd_pkg.sv
rtl/core/smd_ifs.sv
rtl/core/smd_ram.sv
rtl/core/smd_div.sv
rtl/core/smd_front.sv
rtl/core/smd_back.sv
rtl/core/sorted_intensity_mismatch_distance.sv
test/tb_sorted_intensity_mismatch_distance.sv
